// ----- rtl/asrp_pkg.sv -----
// ----------------------------------------------------------------------------
// asrp_pkg
// Types and constants shared by the signed reading parser.
// ----------------------------------------------------------------------------
package asrp_pkg;

    localparam int MAX_READINGS = 8;
    localparam logic [3:0] READ_CAP = 4'((MAX_READINGS > 15) ? 15 : MAX_READINGS);

    localparam logic [3:0] EXPECTED_RESET = 4'd8;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_GT    = 8'h3E;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_MISMATCH   = 2'd2;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SIGN,
        PH_NUM,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic        valid;
        logic [7:0]  rx_byte;
    } t_in_stage;

    typedef struct packed {
        logic signed [31:0] reading;
        logic               reading_valid;
        logic [2:0]         reading_index;
        logic               frame_done;
        logic [1:0]         frame_status;
        logic [3:0]         parsed_count;
    } t_result;

endpackage

// ----- rtl/asrp_byte_if.sv -----
// ----------------------------------------------------------------------------
// asrp_byte_if
// Received byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface asrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/asrp_res_if.sv -----
// ----------------------------------------------------------------------------
// asrp_res_if
// Result channel carrying readings and frame status.
// ----------------------------------------------------------------------------
interface asrp_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] reading;
    logic               reading_valid;
    logic [2:0]         reading_index;
    logic               frame_done;
    logic [1:0]         frame_status;
    logic [3:0]         parsed_count;

    modport source (
        output valid, output reading, output reading_valid, output reading_index,
        output frame_done, output frame_status, output parsed_count, input ready
    );
    modport sink (
        input valid, input reading, input reading_valid, input reading_index,
        input frame_done, input frame_status, input parsed_count, output ready
    );
endinterface

// ----- rtl/asrp_cfg_if.sv -----
// ----------------------------------------------------------------------------
// asrp_cfg_if
// Configuration write channel for the expected reading count.
// ----------------------------------------------------------------------------
interface asrp_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] expected_count;

    modport source (output valid, output expected_count, input ready);
    modport sink (input valid, input expected_count, output ready);
endinterface

// ----- rtl/ascii_signed_reading_parser.sv -----
// ----------------------------------------------------------------------------
// ascii_signed_reading_parser
// Path: each byte is held in the input register, parsed, and its result is held in the output register.
// Throughput: one byte per cycle while the result sink does not stall the output register.
// Reset: synchronous; frame parsing restarts at the header, expected count 8.
// ----------------------------------------------------------------------------
module ascii_signed_reading_parser
    import asrp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    asrp_byte_if.sink     i_rx,
    asrp_cfg_if.sink      i_cfg,
    asrp_res_if.source    o_res
);

    logic [3:0] r_expected_count;
    t_in_stage  in_stage;
    logic       step;
    logic       emit;
    t_result    result;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_count <= EXPECTED_RESET;
        end else if (i_cfg.valid) begin
            r_expected_count <= i_cfg.expected_count;
        end
    end

    assign step = in_stage.valid && (!o_res.valid || o_res.ready);

    asrp_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (step),
        .o_stage (in_stage)
    );

    asrp_parse u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (step),
        .i_byte           (in_stage.rx_byte),
        .i_expected_count (r_expected_count),
        .o_emit           (emit),
        .o_result         (result)
    );

    asrp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && emit),
        .i_result (result),
        .o_res    (o_res)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |-> !step)
        else $error("Parser advanced while a result was still held.");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && emit |=> o_res.valid)
        else $error("Result was lost on its way to the output.");

    a_idle_no_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_stage.valid |-> !step)
        else $error("Parser advanced without a held byte.");

endmodule

// ----- rtl/asrp_in_reg.sv -----
// ----------------------------------------------------------------------------
// asrp_in_reg
// Input register holding one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module asrp_in_reg
    import asrp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    asrp_byte_if.sink     i_rx,
    input  logic          i_take,
    output t_in_stage     o_stage
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign i_rx.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_stage.valid   = r_valid;
    assign o_stage.rx_byte = r_byte;

endmodule

// ----- rtl/asrp_parse.sv -----
// ----------------------------------------------------------------------------
// asrp_parse
// Frame parser state and the per-byte decision logic.
// ----------------------------------------------------------------------------
module asrp_parse
    import asrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic [3:0] i_expected_count,
    output logic       o_emit,
    output t_result    o_result
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_accum, n_accum;
    logic        r_negative, n_negative;
    logic        r_point_seen, n_point_seen;
    logic [3:0]  r_count, n_count;

    logic        is_cr, is_end, is_sign, is_digit;
    t_phase      after_done;
    logic [3:0]  limit;
    logic [3:0]  count_inc;
    logic [31:0] accum_next;

    assign is_cr      = (i_byte == CH_CR);
    assign is_end     = is_cr || (i_byte == CH_NUL);
    assign is_sign    = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);
    assign is_digit   = i_byte inside {[CH_ZERO:CH_NINE]};
    assign after_done = is_cr ? PH_HEADER : PH_SKIP;
    assign limit      = (i_expected_count < READ_CAP) ? i_expected_count : READ_CAP;
    assign count_inc  = r_count + 4'd1;
    assign accum_next = {r_accum[28:0], 3'b000} + {r_accum[30:0], 1'b0}
                      + {28'd0, i_byte[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_accum      <= '0;
            r_negative   <= 1'b0;
            r_point_seen <= 1'b0;
            r_count      <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_accum      <= n_accum;
            r_negative   <= n_negative;
            r_point_seen <= n_point_seen;
            r_count      <= n_count;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_accum      = r_accum;
        n_negative   = r_negative;
        n_point_seen = r_point_seen;
        n_count      = r_count;
        o_emit       = 1'b0;
        o_result     = '0;
        case (r_phase)
            PH_SKIP: begin
                if (is_cr) begin
                    n_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (i_byte == CH_GT) begin
                    n_count = '0;
                    n_phase = PH_SIGN;
                end else begin
                    o_emit                = 1'b1;
                    o_result.frame_done   = 1'b1;
                    o_result.frame_status = ST_BAD_HEADER;
                    n_phase               = after_done;
                end
            end
            PH_SIGN: begin
                if (is_sign) begin
                    n_negative   = (i_byte == CH_MINUS);
                    n_accum      = '0;
                    n_point_seen = 1'b0;
                    n_phase      = PH_NUM;
                end else begin
                    o_emit                = 1'b1;
                    o_result.frame_done   = 1'b1;
                    o_result.frame_status = (i_expected_count == 4'd0) ? ST_OK : ST_MISMATCH;
                    n_phase               = after_done;
                end
            end
            PH_NUM: begin
                if (is_digit) begin
                    n_accum = accum_next;
                end else if ((i_byte == CH_POINT) && !r_point_seen) begin
                    n_point_seen = 1'b1;
                end else if (is_sign || is_end) begin
                    o_emit = 1'b1;
                    if (r_count >= limit) begin
                        o_result.frame_done   = 1'b1;
                        o_result.frame_status = ST_MISMATCH;
                        o_result.parsed_count = limit + 4'd1;
                        n_phase               = after_done;
                    end else begin
                        o_result.reading       = r_negative ? -r_accum : r_accum;
                        o_result.reading_valid = 1'b1;
                        o_result.reading_index = r_count[2:0];
                        n_count                = count_inc;
                        if (is_end) begin
                            o_result.frame_done   = 1'b1;
                            o_result.frame_status =
                                (count_inc == i_expected_count) ? ST_OK : ST_MISMATCH;
                            o_result.parsed_count = count_inc;
                            n_phase               = after_done;
                        end else begin
                            n_accum      = '0;
                            n_point_seen = 1'b0;
                            n_negative   = (i_byte == CH_MINUS);
                        end
                    end
                end else begin
                    o_emit                = 1'b1;
                    o_result.frame_done   = 1'b1;
                    o_result.frame_status =
                        (r_count == i_expected_count) ? ST_OK : ST_MISMATCH;
                    o_result.parsed_count = r_count;
                    n_phase               = after_done;
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
    end

    a_bad_header_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit && (o_result.frame_status == ST_BAD_HEADER)
        |-> (o_result.parsed_count == 4'd0) && !o_result.reading_valid)
        else $error("Bad header result carries a reading or a count.");

    a_count_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_emit && o_result.reading_valid
        |=> r_count == $past(r_count) + 4'd1)
        else $error("Reading emitted without advancing the count.");

    a_done_leaves_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_emit && o_result.frame_done && !is_cr
        |=> r_phase == PH_SKIP)
        else $error("Parser did not skip the rest of a finished frame.");

    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_NUM) && (r_count != 4'd0) |-> r_count <= READ_CAP)
        else $error("Reading count beyond the reading cap.");

endmodule

// ----- rtl/asrp_out_reg.sv -----
// ----------------------------------------------------------------------------
// asrp_out_reg
// Result register that holds one transaction until the sink takes it.
// ----------------------------------------------------------------------------
module asrp_out_reg
    import asrp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_result       i_result,
    asrp_res_if.source    o_res
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.reading       = r_result.reading;
    assign o_res.reading_valid = r_result.reading_valid;
    assign o_res.reading_index = r_result.reading_index;
    assign o_res.frame_done    = r_result.frame_done;
    assign o_res.frame_status  = r_result.frame_status;
    assign o_res.parsed_count  = r_result.parsed_count;

endmodule
